>>> design/crc_pkg.sv
// Shared types and constants for the chain region coordinates unit.
// No dependencies; every other file imports this package.
package crc_pkg;

    localparam int CRC_POS_W  = 31;
    localparam int CRC_WORD_W = 32;
    localparam int CRC_SPAN_W = 8;

    // Anchor queue between the front and back parts
    localparam int CRC_QDEPTH = 2;
    localparam int CRC_QPTR_W = $clog2(CRC_QDEPTH);
    localparam int CRC_QCNT_W = $clog2(CRC_QDEPTH + 1);

    // One classified anchor as it travels through the queue
    typedef struct packed {
        logic                          first;
        logic                          last;
        logic                          strand;
        logic [CRC_POS_W-1:0]          ref_id;
        logic [CRC_POS_W-1:0]          ref_pos;
        logic [CRC_POS_W-1:0]          query_pos;
        logic [CRC_SPAN_W-1:0]         span;
        logic signed [CRC_WORD_W-1:0]  tl;
        logic signed [CRC_WORD_W-1:0]  ql;
    } crc_item_t;

    // Queue handshake status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic not_empty;
    } crc_qstat_t;

endpackage

>>> design/crc_intf.sv
// Channel interfaces: anchor input, region output and configuration write.
// Depends on crc_pkg for field widths.
interface crc_anchor_if;
    import crc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  strand;
    logic [CRC_POS_W-1:0]  ref_id;
    logic [CRC_POS_W-1:0]  ref_pos;
    logic [CRC_POS_W-1:0]  query_pos;
    logic [CRC_SPAN_W-1:0] seed_span;
    logic                  last_anchor;
    modport source (output valid, strand, ref_id, ref_pos, query_pos, seed_span,
                    last_anchor, input ready);
    modport sink   (input valid, strand, ref_id, ref_pos, query_pos, seed_span,
                    last_anchor, output ready);
endinterface

interface crc_region_if;
    import crc_pkg::*;
    logic                         valid;
    logic                         ready;
    logic                         out_strand;
    logic [CRC_POS_W-1:0]         out_ref_id;
    logic [CRC_POS_W-1:0]         ref_start;
    logic signed [CRC_WORD_W-1:0] ref_end;
    logic signed [CRC_WORD_W-1:0] query_start;
    logic signed [CRC_WORD_W-1:0] query_end;
    logic signed [CRC_WORD_W-1:0] matched_len;
    logic signed [CRC_WORD_W-1:0] block_len;
    modport source (output valid, out_strand, out_ref_id, ref_start, ref_end,
                    query_start, query_end, matched_len, block_len, input ready);
    modport sink   (input valid, out_strand, out_ref_id, ref_start, ref_end,
                    query_start, query_end, matched_len, block_len, output ready);
endinterface

interface crc_cfg_if;
    import crc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CRC_POS_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/crc_front.sv
// Front part: accepts anchor words, marks chain first/last, and forms the
// position differences against the previous anchor. Depends on crc_pkg.
module crc_front (
    input  logic                clk,
    input  logic                rst_n,
    crc_anchor_if.sink          anchor,
    input  crc_pkg::crc_qstat_t qstat,
    output logic                push,
    output crc_pkg::crc_item_t  push_item
);
    import crc_pkg::*;

    logic                 open_reg, open_next;
    logic [CRC_POS_W-1:0] prev_ref_reg, prev_ref_next;
    logic [CRC_POS_W-1:0] prev_qry_reg, prev_qry_next;

    assign anchor.ready = !qstat.full;
    assign push         = anchor.valid && anchor.ready;

    always_comb
    begin
        push_item.first     = !open_reg;
        push_item.last      = anchor.last_anchor;
        push_item.strand    = anchor.strand;
        push_item.ref_id    = anchor.ref_id;
        push_item.ref_pos   = anchor.ref_pos;
        push_item.query_pos = anchor.query_pos;
        push_item.span      = anchor.seed_span;
        push_item.tl        = {1'b0, anchor.ref_pos} - {1'b0, prev_ref_reg};
        push_item.ql        = {1'b0, anchor.query_pos} - {1'b0, prev_qry_reg};
    end

    always_comb
    begin
        open_next     = open_reg;
        prev_ref_next = prev_ref_reg;
        prev_qry_next = prev_qry_reg;
        if (push)
        begin
            open_next     = !anchor.last_anchor;
            prev_ref_next = anchor.ref_pos;
            prev_qry_next = anchor.query_pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= 1'b0;
        else
            open_reg <= open_next;
    end

    always_ff @(posedge clk)
    begin
        prev_ref_reg <= prev_ref_next;
        prev_qry_reg <= prev_qry_next;
    end

endmodule

>>> design/crc_queue.sv
// Short queue of classified anchors between the front and back parts.
// Depends on crc_pkg for the item type and depth.
module crc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  crc_pkg::crc_item_t  push_item,
    input  logic                pop,
    output crc_pkg::crc_item_t  head,
    output crc_pkg::crc_qstat_t qstat
);
    import crc_pkg::*;

    crc_item_t               slot_reg [CRC_QDEPTH];
    logic [CRC_QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CRC_QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CRC_QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [CRC_QPTR_W-1:0] bump(input logic [CRC_QPTR_W-1:0] p);
        if (p == CRC_QPTR_W'(CRC_QDEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    assign head            = slot_reg[rd_ptr_reg];
    assign qstat.full      = (count_reg == CRC_QCNT_W'(CRC_QDEPTH));
    assign qstat.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CRC_QCNT_W'(push) - CRC_QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

>>> design/crc_back.sv
// Back part: folds queued anchors into the running lengths, keeps the first
// anchor's fields, and registers the region word. Depends on crc_pkg.
module crc_back (
    input  logic                clk,
    input  logic                rst_n,
    crc_cfg_if.sink             cfg,
    input  crc_pkg::crc_item_t  head,
    input  crc_pkg::crc_qstat_t qstat,
    output logic                pop,
    crc_region_if.source        region
);
    import crc_pkg::*;

    logic [CRC_POS_W-1:0]         qlen_reg;
    logic                         fstrand_reg;
    logic [CRC_POS_W-1:0]         frid_reg;
    logic [CRC_POS_W-1:0]         frs_reg;
    logic [CRC_WORD_W-1:0]        ffq_reg;
    logic [CRC_WORD_W-1:0]        match_reg, match_next;
    logic [CRC_WORD_W-1:0]        block_reg, block_next;
    logic                         out_valid_reg;

    logic                         out_strand_reg;
    logic [CRC_POS_W-1:0]         out_rid_reg, out_rs_reg;
    logic [CRC_WORD_W-1:0]        out_re_reg, out_qs_reg, out_qe_reg;
    logic [CRC_WORD_W-1:0]        out_m_reg, out_b_reg;

    logic signed [CRC_WORD_W-1:0] sp, bigger, smaller, add_m;
    logic [CRC_WORD_W-1:0]        r1, fq, lq, qlen_w;
    logic [CRC_POS_W-1:0]         rs;
    logic                         cur_strand;
    logic [CRC_POS_W-1:0]         cur_rid, cur_rs;
    logic [CRC_WORD_W-1:0]        cur_fq;

    assign cfg.ready = 1'b1;

    // A last anchor drops into the output register only when it is free or being drained; others pop freely
    assign pop = qstat.not_empty && (!head.last || !out_valid_reg || region.ready);

    always_comb
    begin
        sp      = {{(CRC_WORD_W-CRC_SPAN_W){1'b0}}, head.span};
        bigger  = (head.tl > head.ql) ? head.tl : head.ql;
        smaller = (head.tl < head.ql) ? head.tl : head.ql;
        add_m   = (head.tl > sp && head.ql > sp) ? sp : smaller;
        if (head.first)
        begin
            match_next = sp;
            block_next = sp;
        end
        else
        begin
            match_next = match_reg + add_m;
            block_next = block_reg + bigger;
        end

        // First-anchor derived coordinates
        r1 = {1'b0, head.ref_pos} + 1'b1;
        rs = ($signed(r1) > sp) ? CRC_POS_W'(r1 - sp) : '0;
        fq = {1'b0, head.query_pos} + 1'b1 - sp;

        cur_strand = head.first ? head.strand : fstrand_reg;
        cur_rid    = head.first ? head.ref_id : frid_reg;
        cur_rs     = head.first ? rs          : frs_reg;
        cur_fq     = head.first ? fq          : ffq_reg;

        lq     = {1'b0, head.query_pos} + 1'b1;
        qlen_w = {1'b0, qlen_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qlen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                qlen_reg <= cfg.data;
            if (pop && head.last)
                out_valid_reg <= 1'b1;
            else if (region.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            match_reg <= match_next;
            block_reg <= block_next;
            if (head.first)
            begin
                fstrand_reg <= head.strand;
                frid_reg    <= head.ref_id;
                frs_reg     <= rs;
                ffq_reg     <= fq;
            end
        end
        if (pop && head.last)
        begin
            out_strand_reg <= cur_strand;
            out_rid_reg    <= cur_rid;
            out_rs_reg     <= cur_rs;
            out_re_reg     <= {1'b0, head.ref_pos} + 1'b1;
            out_qs_reg     <= cur_strand ? qlen_w - lq : cur_fq;
            out_qe_reg     <= cur_strand ? qlen_w - cur_fq : lq;
            out_m_reg      <= match_next;
            out_b_reg      <= block_next;
        end
    end

    assign region.valid       = out_valid_reg;
    assign region.out_strand  = out_strand_reg;
    assign region.out_ref_id  = out_rid_reg;
    assign region.ref_start   = out_rs_reg;
    assign region.ref_end     = out_re_reg;
    assign region.query_start = out_qs_reg;
    assign region.query_end   = out_qe_reg;
    assign region.matched_len = out_m_reg;
    assign region.block_len   = out_b_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !region.ready) |-> !(pop && head.last))
        else $error("region word overwritten while stalled");

    a_last_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head.last) |=> out_valid_reg)
        else $error("last anchor popped without a region word");

    a_mid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.last && out_valid_reg && !region.ready) |=> $stable(out_m_reg))
        else $error("middle anchor disturbed a waiting region word");

endmodule

>>> design/chain_region_coordinates_unit.sv
// Top level of the chain region coordinates unit: front, queue and back.
// Depends on crc_pkg, crc_intf.sv, crc_front, crc_queue and crc_back.
//
//  channel  | role   | word
//  ---------+--------+-------------------------------------------------------
//  anchor   | sink   | strand, ref_id, ref_pos, query_pos, seed_span, last_anchor
//  region   | source | out_strand, out_ref_id, ref/query start+end, lengths
//  cfg      | sink   | query_length (31 bits), always ready
//
// One anchor word is taken every cycle while the queue is not full; the
// compare/add path in the back part is combinational. A region word passes
// from a queue slot to the output register after its last anchor is taken.
// Reset clears the chain-open flag, the queue pointers, the output valid and
// query_length; no clearing pass is needed. A stalled region word holds while
// the front keeps taking anchors until the two-entry queue fills.
module chain_region_coordinates_unit (
    input  logic        clk,
    input  logic        rst_n,
    crc_anchor_if.sink  anchor,
    crc_region_if.source region,
    crc_cfg_if.sink     cfg
);
    import crc_pkg::*;

    crc_qstat_t qstat;
    crc_item_t  push_item;
    crc_item_t  head;
    logic       push;
    logic       pop;

    // Classify anchors and form differences against the previous one
    crc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .anchor    (anchor),
        .qstat     (qstat),
        .push      (push),
        .push_item (push_item)
    );

    // Hold classified anchors so each side can stall on its own
    crc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Accumulate lengths and register the region word
    crc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .head   (head),
        .qstat  (qstat),
        .pop    (pop),
        .region (region)
    );

endmodule
